// File: hdl/wsf_pkg.sv
package wsf_pkg;

    // default speed datapath width
    localparam int SPEED_WIDTH_DEF = 16;

    // filter weight: Q0.10, saturates at 0.85
    localparam logic [10:0] ALPHA_ONE       = 11'd1024;
    localparam logic [9:0]  ALPHA_MAX       = 10'd870;
    localparam int          ALPHA_SAT_DIFF  = 34;
    // divide by 3072 is a shift by 10 followed by a divide by 3
    localparam int          DIV_SHIFT       = 10;
    // Q8.8 gains
    localparam int          GAIN_FRAC       = 8;
    localparam int          MAC_B_WIDTH     = 17;

    // apb register map
    localparam int CFG_ADDR_WIDTH = 5;
    localparam int CFG_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_LEFT_DUTY_MAX  = 3'd2,
        REG_LEFT_DUTY_MIN  = 3'd3,
        REG_RIGHT_DUTY_MAX = 3'd4,
        REG_RIGHT_DUTY_MIN = 3'd5
    } cfg_reg_t;

    localparam logic [15:0]        PROP_GAIN_RST  = 16'd2381;
    localparam logic [15:0]        INTEG_GAIN_RST = 16'd159;
    localparam logic signed [15:0] DUTY_MAX_RST   = 16'sd900;
    localparam logic signed [15:0] DUTY_MIN_RST   = -16'sd900;

    typedef struct packed {
        logic [15:0]        prop_gain;
        logic [15:0]        integ_gain;
        logic signed [15:0] left_duty_max;
        logic signed [15:0] left_duty_min;
        logic signed [15:0] right_duty_max;
        logic signed [15:0] right_duty_min;
    } cfg_t;

    typedef struct packed {
        logic [14:0]        left_count;
        logic               left_dir;
        logic [14:0]        right_count;
        logic               right_dir;
        logic signed [15:0] left_target;
        logic signed [15:0] right_target;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        left_magnitude;
        logic               left_reverse;
        logic [15:0]        right_magnitude;
        logic               right_reverse;
        logic signed [15:0] left_speed_out;
        logic signed [15:0] right_speed_out;
    } out_item_t;

    typedef enum logic [0:0] {
        MAC_LOAD = 1'b0,
        MAC_ACC  = 1'b1
    } mac_op_t;

    // floor(d * 1024 / 40) for differences below the saturation point
    function automatic logic [9:0] alpha_lut(input logic [5:0] d);
        logic [9:0] r;
        case (d)
            6'd0:    r = 10'd0;
            6'd1:    r = 10'd25;
            6'd2:    r = 10'd51;
            6'd3:    r = 10'd76;
            6'd4:    r = 10'd102;
            6'd5:    r = 10'd128;
            6'd6:    r = 10'd153;
            6'd7:    r = 10'd179;
            6'd8:    r = 10'd204;
            6'd9:    r = 10'd230;
            6'd10:   r = 10'd256;
            6'd11:   r = 10'd281;
            6'd12:   r = 10'd307;
            6'd13:   r = 10'd332;
            6'd14:   r = 10'd358;
            6'd15:   r = 10'd384;
            6'd16:   r = 10'd409;
            6'd17:   r = 10'd435;
            6'd18:   r = 10'd460;
            6'd19:   r = 10'd486;
            6'd20:   r = 10'd512;
            6'd21:   r = 10'd537;
            6'd22:   r = 10'd563;
            6'd23:   r = 10'd588;
            6'd24:   r = 10'd614;
            6'd25:   r = 10'd640;
            6'd26:   r = 10'd665;
            6'd27:   r = 10'd691;
            6'd28:   r = 10'd716;
            6'd29:   r = 10'd742;
            6'd30:   r = 10'd768;
            6'd31:   r = 10'd793;
            6'd32:   r = 10'd819;
            6'd33:   r = 10'd844;
            default: r = ALPHA_MAX;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/wheel_speed_filter_pi_loop_core.sv
// each transaction runs the left wheel and then the right wheel through the sequencer states, with
//   D = ceil((max(SPEED_WIDTH+13, 29) - 10) / 8) passes of the divide-by-3 unit (3 at default)
// a new transaction is taken only when the core is idle again; the two wheels
//   run in turn through one shared multiply-accumulate unit and one divide-by-3 unit
// a stalled result holds the core in its last state until the result is taken
// reset: rst_n clears control, history, errors and duties; config takes its reset values
module wheel_speed_filter_pi_loop_core #(
    parameter int SPEED_WIDTH = wsf_pkg::SPEED_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  wsf_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output wsf_pkg::out_item_t                 out_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wsf_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [wsf_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [wsf_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                               pready
);
    import wsf_pkg::*;

    localparam int SW = SPEED_WIDTH;
    localparam int MA = (SW + 2 > 18) ? SW + 2 : 18;
    localparam int AW = MA + MAC_B_WIDTH + 1;
    localparam int NW = (SW + 13 > 29) ? SW + 13 : 29;
    localparam int DW = NW - DIV_SHIFT;
    localparam int TW = ((SW > 16) ? SW : 16) + 1;

    localparam logic signed [SW-1:0] SPD_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SPD_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_PREP = 12'b0000_0000_0010,
        ST_MUL1 = 12'b0000_0000_0100,
        ST_MUL2 = 12'b0000_0000_1000,
        ST_DIV0 = 12'b0000_0001_0000,
        ST_DIVW = 12'b0000_0010_0000,
        ST_SPD  = 12'b0000_0100_0000,
        ST_ERR  = 12'b0000_1000_0000,
        ST_MUL3 = 12'b0001_0000_0000,
        ST_MUL4 = 12'b0010_0000_0000,
        ST_DUTY = 12'b0100_0000_0000,
        ST_DONE = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   wh_reg;

    cfg_t   cfg;

    // state per wheel
    logic signed [SW-1:0] hist_reg [2][3];
    logic signed [SW-1:0] prev_reg [2];
    logic signed [15:0]   duty_reg [2];

    // per-item working registers
    in_item_t             in_reg;
    logic signed [17:0]   x3_reg;
    logic signed [SW+1:0] sum_reg;
    logic [9:0]           alpha_reg;
    logic                 neg_reg;
    logic signed [SW-1:0] y_reg;
    logic signed [SW-1:0] e_reg;
    logic signed [SW:0]   de_reg;
    logic signed [15:0]   spd_reg [2];
    logic                 out_valid_reg;
    out_item_t            out_item_reg;

    // shared unit hookup
    logic                   mac_en;
    mac_op_t                mac_op;
    logic signed [MA-1:0]   mac_a;
    logic signed [MAC_B_WIDTH-1:0] mac_b;
    logic signed [AW-1:0]   acc;
    logic                   div_start;
    logic                   div_done;
    logic [DW-1:0]          div_dividend;
    logic [DW-1:0]          div_quot;

    // combinational step results
    logic [14:0]          cnt_cur;
    logic                 cnt_neg;
    logic signed [15:0]   x_cur;
    logic signed [SW-1:0] h0;
    logic signed [SW-1:0] h1;
    logic signed [SW-1:0] h2;
    logic signed [TW-1:0] dx;
    logic [TW-1:0]        dx_abs;
    logic [9:0]           alpha_next;
    logic signed [17:0]   x3_next;
    logic signed [SW+1:0] sum_next;
    logic signed [NW-1:0] num;
    logic [NW-1:0]        num_mag;
    logic signed [DW:0]   qs;
    logic signed [SW-1:0] y_next;
    logic signed [15:0]   target_cur;
    logic signed [TW-1:0] err_raw;
    logic signed [SW-1:0] e_next;
    logic signed [SW:0]   de_next;
    logic signed [AW-1:0] delta;
    logic signed [AW-1:0] duty_sum;
    logic signed [15:0]   dmax;
    logic signed [15:0]   dmin;
    logic signed [15:0]   duty_next;
    logic signed [SW+15:0] y_wide;
    logic                 out_load;

    wsf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wsf_mac #(
        .A_WIDTH (MA)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (mac_en),
        .op    (mac_op),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    wsf_div3 #(
        .DIV_WIDTH (DW)
    ) u_div3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // filter setup: signed speed, weight, history sum
    always_comb
    begin
        cnt_cur  = wh_reg ? in_reg.right_count : in_reg.left_count;
        cnt_neg  = wh_reg ? ~in_reg.right_dir : in_reg.left_dir;
        x_cur    = cnt_neg ? -$signed({1'b0, cnt_cur}) : $signed({1'b0, cnt_cur});
        h0       = hist_reg[wh_reg][0];
        h1       = hist_reg[wh_reg][1];
        h2       = hist_reg[wh_reg][2];
        dx       = TW'(x_cur) - TW'(h0);
        dx_abs   = dx[TW-1] ? TW'(-dx) : TW'(dx);
        alpha_next = (dx_abs < TW'(ALPHA_SAT_DIFF)) ? alpha_lut(dx_abs[5:0]) : ALPHA_MAX;
        x3_next  = 18'(x_cur) + (18'(x_cur) <<< 1);
        sum_next = (SW+2)'(h0) + (SW+2)'(h1) + (SW+2)'(h2);
    end

    // shared multiplier operand selection
    always_comb
    begin
        mac_en = 1'b0;
        mac_op = MAC_LOAD;
        mac_a  = '0;
        mac_b  = '0;
        case (state_reg)
            ST_MUL1:
            begin
                mac_en = 1'b1;
                mac_op = MAC_LOAD;
                mac_a  = MA'(x3_reg);
                mac_b  = $signed({6'd0, ALPHA_ONE - {1'b0, alpha_reg}});
            end
            ST_MUL2:
            begin
                mac_en = 1'b1;
                mac_op = MAC_ACC;
                mac_a  = MA'(sum_reg);
                mac_b  = $signed({7'd0, alpha_reg});
            end
            ST_MUL3:
            begin
                mac_en = 1'b1;
                mac_op = MAC_LOAD;
                mac_a  = MA'(de_reg);
                mac_b  = $signed({1'b0, cfg.prop_gain});
            end
            ST_MUL4:
            begin
                mac_en = 1'b1;
                mac_op = MAC_ACC;
                mac_a  = MA'(e_reg);
                mac_b  = $signed({1'b0, cfg.integ_gain});
            end
            default:
            begin
                mac_en = 1'b0;
            end
        endcase
    end

    // filter numerator to magnitude, divide by 1024 then by 3
    assign num          = $signed(acc[NW-1:0]);
    assign num_mag      = num[NW-1] ? NW'(-num) : NW'(num);
    assign div_dividend = num_mag[NW-1:DIV_SHIFT];
    assign div_start    = (state_reg == ST_DIV0);

    // filtered speed: restore sign and saturate
    always_comb
    begin
        qs = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        if (qs > (DW+1)'(SPD_MAX))
        begin
            y_next = SPD_MAX;
        end
        else if (qs < (DW+1)'(SPD_MIN))
        begin
            y_next = SPD_MIN;
        end
        else
        begin
            y_next = SW'(qs);
        end
    end

    // speed error and its increment
    always_comb
    begin
        target_cur = wh_reg ? in_reg.right_target : in_reg.left_target;
        err_raw    = TW'(target_cur) - TW'(y_reg);
        if (err_raw > TW'(SPD_MAX))
        begin
            e_next = SPD_MAX;
        end
        else if (err_raw < TW'(SPD_MIN))
        begin
            e_next = SPD_MIN;
        end
        else
        begin
            e_next = SW'(err_raw);
        end
        de_next = (SW+1)'(e_next) - (SW+1)'(prev_reg[wh_reg]);
    end

    // duty update: truncate toward zero, add, clamp max then min
    always_comb
    begin
        delta    = acc[AW-1] ? ((acc + AW'((1 << GAIN_FRAC) - 1)) >>> GAIN_FRAC)
                             : (acc >>> GAIN_FRAC);
        duty_sum = AW'(duty_reg[wh_reg]) + delta;
        dmax     = wh_reg ? cfg.right_duty_max : cfg.left_duty_max;
        dmin     = wh_reg ? cfg.right_duty_min : cfg.left_duty_min;
        duty_next = duty_sum[15:0];
        if (duty_sum > AW'(dmax))
        begin
            duty_next = dmax;
        end
        if (duty_next > dmin)
        begin
            duty_next = duty_next;
        end
        if ((duty_sum > AW'(dmax) ? AW'(dmax) : duty_sum) < AW'(dmin))
        begin
            duty_next = dmin;
        end
    end

    // sequencer
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: state_next = in_valid ? ST_PREP : ST_IDLE;
            ST_PREP: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DIV0;
            ST_DIV0: state_next = ST_DIVW;
            ST_DIVW: state_next = div_done ? ST_SPD : ST_DIVW;
            ST_SPD:  state_next = ST_ERR;
            ST_ERR:  state_next = ST_MUL3;
            ST_MUL3: state_next = ST_MUL4;
            ST_MUL4: state_next = ST_DUTY;
            ST_DUTY: state_next = wh_reg ? ST_DONE : ST_PREP;
            ST_DONE: state_next = out_load ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wh_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int w = 0; w < 2; w++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    hist_reg[w][k] <= '0;
                end
                prev_reg[w] <= '0;
                duty_reg[w] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DUTY)
            begin
                wh_reg             <= ~wh_reg;
                duty_reg[wh_reg]   <= duty_next;
            end
            if (state_reg == ST_SPD)
            begin
                hist_reg[wh_reg][2] <= hist_reg[wh_reg][1];
                hist_reg[wh_reg][1] <= hist_reg[wh_reg][0];
                hist_reg[wh_reg][0] <= y_next;
            end
            if (state_reg == ST_ERR)
            begin
                prev_reg[wh_reg] <= e_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // speed output field is the low 16 bits of the sign-extended speed
    assign y_wide = (SW+16)'(y_next);

    // payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            in_reg <= in_item;
        end
        if (state_reg == ST_PREP)
        begin
            x3_reg    <= x3_next;
            sum_reg   <= sum_next;
            alpha_reg <= alpha_next;
        end
        if (state_reg == ST_DIV0)
        begin
            neg_reg <= num[NW-1];
        end
        if (state_reg == ST_SPD)
        begin
            y_reg           <= y_next;
            spd_reg[wh_reg] <= y_wide[15:0];
        end
        if (state_reg == ST_ERR)
        begin
            e_reg  <= e_next;
            de_reg <= de_next;
        end
        if (out_load)
        begin
            out_item_reg.left_magnitude  <= duty_reg[0][15] ? 16'(-duty_reg[0])
                                                            : 16'(duty_reg[0]);
            out_item_reg.left_reverse    <= duty_reg[0][15];
            out_item_reg.right_magnitude <= duty_reg[1][15] ? 16'(-duty_reg[1])
                                                            : 16'(duty_reg[1]);
            out_item_reg.right_reverse   <= duty_reg[1][15];
            out_item_reg.left_speed_out  <= spd_reg[0];
            out_item_reg.right_speed_out <= spd_reg[1];
        end
    end

endmodule

// File: hdl/wsf_cfg.sv
module wsf_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wsf_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
    input  logic [wsf_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
    output logic [wsf_pkg::CFG_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    output wsf_pkg::cfg_t                        cfg
);
    import wsf_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[CFG_ADDR_WIDTH-1:2];
    assign cfg     = cfg_reg;

    // register writes, out-of-range indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= PROP_GAIN_RST;
            cfg_reg.integ_gain     <= INTEG_GAIN_RST;
            cfg_reg.left_duty_max  <= DUTY_MAX_RST;
            cfg_reg.left_duty_min  <= DUTY_MIN_RST;
            cfg_reg.right_duty_max <= DUTY_MAX_RST;
            cfg_reg.right_duty_min <= DUTY_MIN_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PROP_GAIN:      cfg_reg.prop_gain      <= pwdata[15:0];
                REG_INTEG_GAIN:     cfg_reg.integ_gain     <= pwdata[15:0];
                REG_LEFT_DUTY_MAX:  cfg_reg.left_duty_max  <= $signed(pwdata[15:0]);
                REG_LEFT_DUTY_MIN:  cfg_reg.left_duty_min  <= $signed(pwdata[15:0]);
                REG_RIGHT_DUTY_MAX: cfg_reg.right_duty_max <= $signed(pwdata[15:0]);
                REG_RIGHT_DUTY_MIN: cfg_reg.right_duty_min <= $signed(pwdata[15:0]);
                default:            ;
            endcase
        end
    end

    // read mux, signed limits sign-extended
    always_comb
    begin
        case (reg_idx)
            REG_PROP_GAIN:      prdata = {16'd0, cfg_reg.prop_gain};
            REG_INTEG_GAIN:     prdata = {16'd0, cfg_reg.integ_gain};
            REG_LEFT_DUTY_MAX:  prdata = CFG_DATA_WIDTH'(cfg_reg.left_duty_max);
            REG_LEFT_DUTY_MIN:  prdata = CFG_DATA_WIDTH'(cfg_reg.left_duty_min);
            REG_RIGHT_DUTY_MAX: prdata = CFG_DATA_WIDTH'(cfg_reg.right_duty_max);
            REG_RIGHT_DUTY_MIN: prdata = CFG_DATA_WIDTH'(cfg_reg.right_duty_min);
            default:            prdata = '0;
        endcase
    end

endmodule

// File: hdl/wsf_mac.sv
module wsf_mac #(
    parameter int A_WIDTH = 18
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  wsf_pkg::mac_op_t                       op,
    input  logic signed [A_WIDTH-1:0]              a,
    input  logic signed [wsf_pkg::MAC_B_WIDTH-1:0] b,
    output logic signed [A_WIDTH+wsf_pkg::MAC_B_WIDTH:0] acc
);
    import wsf_pkg::*;

    localparam int AW = A_WIDTH + MAC_B_WIDTH + 1;

    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] prod;

    assign prod = AW'(a * b);
    assign acc  = acc_reg;

    // load or accumulate one product
    always_comb
    begin
        case (op)
            MAC_LOAD: acc_next = prod;
            MAC_ACC:  acc_next = acc_reg + prod;
            default:  acc_next = prod;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (en)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// File: hdl/wsf_div3.sv
module wsf_div3 #(
    parameter int DIV_WIDTH = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_WIDTH-1:0] dividend,
    output logic                 done,
    output logic [DIV_WIDTH-1:0] quot
);
    localparam int STEPS = (DIV_WIDTH + 7) / 8;
    localparam int PW    = STEPS * 8;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] sh_reg;
    logic [PW-1:0] q_reg;
    logic [1:0]    r_reg;

    logic [7:0]    qbits;
    logic [1:0]    r_next;
    logic [2:0]    t;
    logic          last;

    assign done = done_reg;
    assign quot = q_reg[DIV_WIDTH-1:0];
    assign last = (cnt_reg == CW'(STEPS - 1));

    // eight radix-2 steps of long division by three, msb first
    always_comb
    begin
        r_next = r_reg;
        qbits  = '0;
        t      = '0;
        for (int i = 0; i < 8; i++)
        begin
            t = {r_next, sh_reg[PW-1-i]};
            if (t >= 3'd3)
            begin
                qbits[7-i] = 1'b1;
                r_next     = 2'(t - 3'd3);
            end
            else
            begin
                r_next = t[1:0];
            end
        end
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg & last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= ~last;
                cnt_reg  <= cnt_reg + CW'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg <= PW'(dividend);
            q_reg  <= '0;
            r_reg  <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg <= sh_reg << 8;
            q_reg  <= PW'({q_reg, qbits});
            r_reg  <= r_next;
        end
    end

endmodule

// File: tb/wheel_speed_filter_pi_loop_core_tb.sv
`timescale 1ns / 100ps

module wheel_speed_filter_pi_loop_core_tb;

    import wsf_pkg::*;

    localparam int    SPEED_W       = SPEED_WIDTH_DEF;
    localparam int    NUM_REGS      = 6;
    localparam int    SETTLE_CYCLES = 64;
    localparam int    MAX_REPORTS   = 10;
    localparam int    LEFT          = 0;
    localparam int    RIGHT         = 1;
    localparam longint FILTER_DIV   = 3 * (1 << DIV_SHIFT);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    in_item_t                  in_item = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_item_t                 out_item;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
    logic [CFG_DATA_WIDTH-1:0] pwdata = '0;
    logic [CFG_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    // stimulus and expected results
    in_item_t  pending_ticks[$];
    out_item_t expected_drive[$];
    int        ticks_queued = 0;
    int        ticks_accepted = 0;
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // predictor state
    cfg_t   model_cfg;
    longint hist[2][3];
    longint prev_err[2];
    longint duty[2];

    // random walk state for well-formed speed sequences
    int walk_l = 0;
    int walk_r = 0;

    wheel_speed_filter_pi_loop_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // saturate to the speed datapath width
    function automatic longint clip_speed(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SPEED_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // adaptive lag filter, shifts the wheel's history
    function automatic longint smooth_speed(int w, longint x);
        longint d;
        longint a;
        longint y;
        d = x - hist[w][0];
        if (d < 0)
            d = -d;
        a = (d * 128) / 5;
        if (a > longint'(ALPHA_MAX))
            a = longint'(ALPHA_MAX);
        y = (3 * x * (longint'(ALPHA_ONE) - a) + (hist[w][0] + hist[w][1] + hist[w][2]) * a)
            / FILTER_DIV;
        y = clip_speed(y);
        hist[w][2] = hist[w][1];
        hist[w][1] = hist[w][0];
        hist[w][0] = y;
        return y;
    endfunction

    // incremental pi update with max clamp first, then min
    function automatic longint step_duty(int w, longint target, longint speed,
                                         longint dmax, longint dmin);
        longint e;
        longint delta;
        longint v;
        e = clip_speed(target - speed);
        delta = (longint'(model_cfg.prop_gain) * (e - prev_err[w])
                 + longint'(model_cfg.integ_gain) * e) / (1 << GAIN_FRAC);
        v = duty[w] + delta;
        if (v > dmax)
            v = dmax;
        if (v < dmin)
            v = dmin;
        prev_err[w] = e;
        duty[w] = v;
        return v;
    endfunction

    // expected drive outputs for one accepted tick
    function automatic out_item_t predict_drive(in_item_t it);
        out_item_t r;
        longint    ls;
        longint    rs;
        longint    ly;
        longint    ry;
        longint    ld;
        longint    rd;
        longint    lm;
        longint    rm;
        ls = it.left_dir ? -longint'(it.left_count) : longint'(it.left_count);
        rs = it.right_dir ? longint'(it.right_count) : -longint'(it.right_count);
        ly = smooth_speed(LEFT, ls);
        ry = smooth_speed(RIGHT, rs);
        ld = step_duty(LEFT, longint'($signed(it.left_target)), ly,
                       longint'($signed(model_cfg.left_duty_max)),
                       longint'($signed(model_cfg.left_duty_min)));
        rd = step_duty(RIGHT, longint'($signed(it.right_target)), ry,
                       longint'($signed(model_cfg.right_duty_max)),
                       longint'($signed(model_cfg.right_duty_min)));
        lm = (ld < 0) ? -ld : ld;
        rm = (rd < 0) ? -rd : rd;
        r.left_magnitude  = lm[15:0];
        r.left_reverse    = (ld < 0);
        r.right_magnitude = rm[15:0];
        r.right_reverse   = (rd < 0);
        r.left_speed_out  = ly[15:0];
        r.right_speed_out = ry[15:0];
        return r;
    endfunction

    // compare one drive result against the oldest expectation
    task automatic check_drive(out_item_t got);
        out_item_t want;
        if (expected_drive.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected result: mag %0d/%0d rev %0d/%0d spd %0d/%0d",
                         got.left_magnitude, got.right_magnitude, got.left_reverse,
                         got.right_reverse, got.left_speed_out, got.right_speed_out);
        end
        else
        begin
            want = expected_drive.pop_front();
            if (got.left_magnitude !== want.left_magnitude
                || got.left_reverse !== want.left_reverse
                || got.right_magnitude !== want.right_magnitude
                || got.right_reverse !== want.right_reverse
                || got.left_speed_out !== want.left_speed_out
                || got.right_speed_out !== want.right_speed_out)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("mismatch exp: lmag %0d lrev %0d rmag %0d rrev %0d ls %0d rs %0d",
                             want.left_magnitude, want.left_reverse, want.right_magnitude,
                             want.right_reverse, want.left_speed_out, want.right_speed_out);
                    $display("         got: lmag %0d lrev %0d rmag %0d rrev %0d ls %0d rs %0d",
                             got.left_magnitude, got.left_reverse, got.right_magnitude,
                             got.right_reverse, got.left_speed_out, got.right_speed_out);
                end
            end
        end
    endtask

    // input driver: predicts on each accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_drive.push_back(predict_drive(in_item));
                ticks_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_item  <= pending_ticks.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_drive(out_item);
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // setup cycle, access cycle, then release the bus
    task automatic apb_write(logic [CFG_ADDR_WIDTH-1:0] addr, logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_reg(cfg_reg_t r, logic [15:0] v);
        apb_write({r, 2'b00}, {{16{v[15]}}, v});
        case (r)
            REG_PROP_GAIN:      model_cfg.prop_gain      = v;
            REG_INTEG_GAIN:     model_cfg.integ_gain     = v;
            REG_LEFT_DUTY_MAX:  model_cfg.left_duty_max  = v;
            REG_LEFT_DUTY_MIN:  model_cfg.left_duty_min  = v;
            REG_RIGHT_DUTY_MAX: model_cfg.right_duty_max = v;
            REG_RIGHT_DUTY_MIN: model_cfg.right_duty_min = v;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [15:0] pg, logic [15:0] ig, logic [15:0] lmax,
                           logic [15:0] lmin, logic [15:0] rmax, logic [15:0] rmin);
        set_reg(REG_PROP_GAIN, pg);
        set_reg(REG_INTEG_GAIN, ig);
        set_reg(REG_LEFT_DUTY_MAX, lmax);
        set_reg(REG_LEFT_DUTY_MIN, lmin);
        set_reg(REG_RIGHT_DUTY_MAX, rmax);
        set_reg(REG_RIGHT_DUTY_MIN, rmin);
    endtask

    task automatic push_tick(int lc, bit ldir, int rc, bit rdir, int lt, int rt);
        in_item_t it;
        it.left_count   = lc[14:0];
        it.left_dir     = ldir;
        it.right_count  = rc[14:0];
        it.right_dir    = rdir;
        it.left_target  = lt[15:0];
        it.right_target = rt[15:0];
        pending_ticks.push_back(it);
        ticks_queued++;
    endtask

    function automatic int clip16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // mostly smooth speed traces with nearby targets, some pure noise
    task automatic push_random_ticks(int n);
        int lt;
        int rt;
        bit ldir;
        bit rdir;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 15)
                push_tick($urandom_range(0, 32767), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 32767), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
            else
            begin
                if ($urandom_range(0, 99) < 4)
                    walk_l = int'($urandom_range(0, 4000)) - 2000;
                else
                    walk_l = clip16(walk_l + int'($urandom_range(0, 40)) - 20);
                if ($urandom_range(0, 99) < 4)
                    walk_r = int'($urandom_range(0, 4000)) - 2000;
                else
                    walk_r = clip16(walk_r + int'($urandom_range(0, 40)) - 20);
                if (walk_l < -32767)
                    walk_l = -32767;
                if (walk_r < -32767)
                    walk_r = -32767;
                lt = clip16(walk_l + int'($urandom_range(0, 400)) - 200);
                rt = clip16(walk_r + int'($urandom_range(0, 400)) - 200);
                if ($urandom_range(0, 99) < 5)
                    lt = int'($urandom_range(0, 65535)) - 32768;
                if ($urandom_range(0, 99) < 5)
                    rt = int'($urandom_range(0, 65535)) - 32768;
                ldir = (walk_l == 0) ? 1'($urandom_range(0, 1)) : (walk_l < 0);
                rdir = (walk_r == 0) ? 1'($urandom_range(0, 1)) : (walk_r > 0);
                push_tick((walk_l < 0) ? -walk_l : walk_l, ldir,
                          (walk_r < 0) ? -walk_r : walk_r, rdir, lt, rt);
            end
        end
    endtask

    // wait for every queued tick to be accepted and answered
    task automatic drain;
        while (ticks_accepted != ticks_queued || expected_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        model_cfg.prop_gain      = PROP_GAIN_RST;
        model_cfg.integ_gain     = INTEG_GAIN_RST;
        model_cfg.left_duty_max  = DUTY_MAX_RST;
        model_cfg.left_duty_min  = DUTY_MIN_RST;
        model_cfg.right_duty_max = DUTY_MAX_RST;
        model_cfg.right_duty_min = DUTY_MIN_RST;
        send_idle_pct = 8;
        recv_idle_pct = 78;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: field extremes, negative zero, small steps through the weight table
        push_tick(0, 0, 0, 0, 0, 0);
        push_tick(32767, 0, 32767, 1, 32767, 32767);
        push_tick(32767, 1, 32767, 0, -32768, -32768);
        push_tick(0, 1, 0, 0, 0, 0);
        for (int k = 0; k < 10; k++)
            push_tick(4 * k, 0, 3 * k, 1, 100, -100);
        push_tick(10, 1, 10, 0, 32767, -32768);
        drain();

        // maximum gains and full-range limits: large sums, most negative duty
        set_all(16'hFFFF, 16'hFFFF, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        push_tick(32767, 0, 32767, 1, -32768, -32768);
        push_tick(32767, 0, 32767, 1, -32768, -32768);
        push_tick(32767, 1, 32767, 0, 32767, 32767);
        push_tick(32767, 1, 32767, 0, 32767, 32767);
        push_random_ticks(150);
        drain();

        send_idle_pct = 78;
        recv_idle_pct = 8;

        // zero gains hold the duty
        set_all(16'd0, 16'd0, DUTY_MAX_RST, DUTY_MIN_RST, DUTY_MAX_RST, DUTY_MIN_RST);
        push_random_ticks(60);
        drain();

        // crossed limits: duty ends at min
        set_all(PROP_GAIN_RST, INTEG_GAIN_RST, -16'sd100, 16'sd200, -16'sd32768, 16'sd32767);
        push_tick(500, 0, 500, 1, -500, -500);
        push_tick(500, 1, 500, 0, 500, 500);
        push_random_ticks(120);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;

        // random settings, plus writes to unmapped addresses that must be ignored
        set_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        apb_write(CFG_ADDR_WIDTH'(NUM_REGS * 4), $urandom());
        apb_write(CFG_ADDR_WIDTH'((NUM_REGS + 1) * 4), $urandom());
        push_random_ticks(200);
        drain();

        // ordinary gains, wide left limits, asymmetric right limits
        set_all(16'd512, 16'd64, 16'sd32767, -16'sd32768, 16'sd1200, -16'sd700);
        push_random_ticks(300);
        drain();

        if (fail_count == 0 && expected_drive.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
